@@ hw/rtl/spmp_pkg.sv @@
// Shared types, constants and helpers of the sprite/playfield mixer and palette unit.
package spmp_pkg;

  // Palette store geometry. The entry count is a power of two, and indexes wrap modulo it.
  localparam int unsigned PAL_AW      = 10;
  localparam int unsigned PAL_ENTRIES = 1 << PAL_AW;

  // Item kinds. Code 3 is unused and is dropped.
  typedef enum logic [1:0] {
    KIND_PAL_WR = 2'd0,
    KIND_INT_WR = 2'd1,
    KIND_PIXEL  = 2'd2
  } kind_e;

  // Multiply by this constant, then shift right by RECIP_SH: x/31 for any x below 2**13.
  localparam logic [15:0] RECIP_31 = 16'd33826;
  localparam int unsigned RECIP_SH = 20;

  typedef logic [2:0][7:0]  chan8_t;
  typedef logic [2:0][12:0] chan13_t;

  // Wrap a 10-bit palette index onto the store.
  function automatic logic [PAL_AW-1:0] pal_index(input logic [9:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[PAL_AW-1:0];
  endfunction

  // 5-bit channel to 8 bits: c*7, plus 38 when nonzero.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [7:0] v;
    v = 8'(c) * 8'd7;
    if (c != 5'd0) v = v + 8'd38;
    return v;
  endfunction

endpackage

@@ hw/rtl/sprite_playfield_mixer_palette_unit.sv @@
// Top level: palette RAM, intensity register and playfield/sprite pixel mixer.
//
// One input channel (in_valid_i/in_ready_o) carries three kinds of item: a palette
// write (word_address_i, write_data_i, byte_enable_i), an intensity write (the low
// five bits of write_data_i, inverted, when byte_enable_i[0] is set) and a pixel
// (pf_pixel_i, pf_priority_i, mo_pixel_i). Only a pixel makes a result, which leaves
// on the output channel (out_valid_o/out_ready_i) as red_o, green_o and blue_o.
// Throughput is one item per cycle outside the clearing sweep while the output drains.
// A pixel passes the palette RAM read at its transfer edge, channel expand and
// multiply by the level, then the divide by 31 (skipped when entry bit 15 is set)
// into the output register. Writes take effect at their transfer, so a pixel that
// follows in the next cycle already sees them. After reset the block sweeps the
// 1024-entry palette RAM to zero, one entry a cycle, with in_ready_o low until done;
// the intensity level resets to zero. When the receiver stalls, each pipeline stage
// holds its pixel and bubbles collapse, so new items are still taken until every stage is full.
module sprite_playfield_mixer_palette_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [9:0]  word_address_i,
  input  logic [15:0] write_data_i,
  input  logic [1:0]  byte_enable_i,
  input  logic [9:0]  pf_pixel_i,
  input  logic [1:0]  pf_priority_i,
  input  logic [9:0]  mo_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);

  localparam int unsigned AW = spmp_pkg::PAL_AW;

  logic [15:0] pal_mem [spmp_pkg::PAL_ENTRIES];

  // Clearing sweep
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic [4:0] level_q, level_d;

  // Pipeline
  logic                s1_valid_q, s1_valid_d;
  logic [15:0]         rdata_q;
  logic [4:0]          s1_level_q;
  logic                s2_valid_q, s2_valid_d;
  logic                s2_dim_q;
  spmp_pkg::chan8_t    s2_v_q, s2_v_d;
  spmp_pkg::chan13_t   s2_prod_q, s2_prod_d;
  logic                out_valid_q, out_valid_d;
  spmp_pkg::chan8_t    out_q, out_d;

  logic s1_free, s2_free, s3_free;
  logic in_xfer, pix_xfer, pal_xfer, int_xfer;

  logic [1:0]    mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic [AW-1:0] rd_addr;
  logic [9:0]    pix_sel;

  assign s3_free = !out_valid_q || out_ready_i;
  assign s2_free = !s2_valid_q || s3_free;
  assign s1_free = !s1_valid_q || s2_free;

  assign in_ready_o = !clr_busy_q && s1_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign pal_xfer   = in_xfer && (kind_i == spmp_pkg::KIND_PAL_WR);
  assign int_xfer   = in_xfer && (kind_i == spmp_pkg::KIND_INT_WR);
  assign pix_xfer   = in_xfer && (kind_i == spmp_pkg::KIND_PIXEL);

  // Sprite wins unless transparent or behind a priority playfield pen.
  always_comb begin
    if ((mo_pixel_i != 10'd0) && ((pf_priority_i == 2'd0) || !pf_pixel_i[3])) begin
      pix_sel = mo_pixel_i;
    end else begin
      pix_sel = pf_pixel_i;
    end
  end
  assign rd_addr = spmp_pkg::pal_index(pix_sel);

  // Write port: the clearing sweep owns it until done.
  always_comb begin
    if (clr_busy_q) begin
      mem_we = 2'b11;
      mem_wa = clr_addr_q;
      mem_wd = 16'h0000;
    end else begin
      mem_we = pal_xfer ? byte_enable_i : 2'b00;
      mem_wa = spmp_pkg::pal_index(word_address_i);
      mem_wd = write_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we[0]) pal_mem[mem_wa][7:0]  <= mem_wd[7:0];
    if (mem_we[1]) pal_mem[mem_wa][15:8] <= mem_wd[15:8];
    if (pix_xfer) rdata_q <= pal_mem[rd_addr];
  end

  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == {AW{1'b1}}) clr_busy_d = 1'b0;
    end
  end

  assign level_d = (int_xfer && byte_enable_i[0]) ? ~write_data_i[4:0] : level_q;

  // Stage 2: expand channels and multiply by the level captured with the pixel.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_v_d[i]    = spmp_pkg::expand5(rdata_q[5*(2-i) +: 5]);
      s2_prod_d[i] = 13'(s2_v_d[i]) * 13'(s1_level_q);
    end
  end

  // Stage 3: divide by 31 through a reciprocal, select dimmed or plain.
  always_comb begin
    logic [28:0] q;
    q = '0;
    for (int i = 0; i < 3; i++) begin
      q = 29'(s2_prod_q[i]) * 29'(spmp_pkg::RECIP_31);
      out_d[i] = s2_dim_q ? q[spmp_pkg::RECIP_SH +: 8] : s2_v_q[i];
    end
  end

  assign s1_valid_d  = pix_xfer ? 1'b1 : (s1_free ? 1'b0 : s1_valid_q);
  assign s2_valid_d  = s2_free ? s1_valid_q : s2_valid_q;
  assign out_valid_d = s3_free ? s2_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      level_q     <= 5'd0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      level_q     <= level_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_xfer) s1_level_q <= level_q;
    if (s2_free) begin
      s2_dim_q  <= !rdata_q[15];
      s2_v_q    <= s2_v_d;
      s2_prod_q <= s2_prod_d;
    end
    if (s3_free) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];

  a_pix_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_xfer |=> s1_valid_q)
    else $error("accepted pixel did not enter the read stage");

  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_valid_q))
    else $error("result appeared without a pixel in stage 2");

  a_no_xfer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_xfer)
    else $error("transfer taken during palette clear");

  a_clear_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> ($past(clr_addr_q) == {AW{1'b1}}))
    else $error("palette clear ended early");

endmodule
